@@ design/sml_frame_receiver_macros.svh @@
// ----------------------------------------------------------------------------
// SML frame receiver assertion macros
// Shared property wrappers for the port checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SML_FRAME_RECEIVER_MACROS_SVH
`define SML_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, off while in reset
`define SFR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sml_frame_receiver: port check failed");

// Next-cycle implication, off while in reset
`define SFR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sml_frame_receiver: port check failed");

// Next-cycle implication that also covers reset itself
`define SFR_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sml_frame_receiver: reset check failed");

`endif

@@ design/sml_frx_pkg.sv @@
// ----------------------------------------------------------------------------
// SML frame receiver package
// Item types, command and status codes, frame sequences and the X-25 CRC step.
// ----------------------------------------------------------------------------
`default_nettype none

package sml_frx_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [9:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] frame_length;
    logic [7:0]  read_data;
  } out_item_t;

  // Command codes
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // Status codes
  localparam logic [2:0] ST_HUNT     = 3'd0;
  localparam logic [2:0] ST_START    = 3'd1;
  localparam logic [2:0] ST_RECV     = 3'd2;
  localparam logic [2:0] ST_GOOD     = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_DROPPED  = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  localparam int START_LENGTH = 8;

  // Oldest byte in the top bits
  localparam logic [63:0] START_SEQ = 64'h1B1B_1B1B_0101_0101;
  localparam logic [39:0] END_SEQ   = 40'h1B_1B1B_1B1A;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // One byte of reflected CRC-16/X-25
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC over the first six start bytes; the last two wait in the lag pair
  localparam logic [15:0] CRC_START =
    crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT,
      8'h1B), 8'h1B), 8'h1B), 8'h1B), 8'h01), 8'h01);

  // Classified item as it waits in the queue
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [9:0] read_index;
    logic       rd_in_range;
    logic       rd_in_win;
  } cls_item_t;

  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

@@ design/sml_frx_front.sv @@
// ----------------------------------------------------------------------------
// SML frame receiver front end
// Accepts items, classifies read positions and queues up to two items for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sml_frx_front #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sml_frx_pkg::in_item_t  in_item,
  output sml_frx_pkg::q_head_t   head,
  input  logic                   pop
);

  sml_frx_pkg::cls_item_t cls;
  sml_frx_pkg::cls_item_t slot_r [2];
  logic                   wr_ptr_r;
  logic                   rd_ptr_r;
  logic [1:0]             cnt_r;
  logic [1:0]             cnt_nxt;
  logic                   push;

  always_comb begin
    cls.kind        = in_item.command;
    cls.rx_byte     = in_item.rx_byte;
    cls.read_index  = in_item.read_index;
    cls.rd_in_range = 32'(in_item.read_index) < 32'(BUFFER_DEPTH);
    cls.rd_in_win   = in_item.read_index < 10'(sml_frx_pkg::START_LENGTH);
  end

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

@@ design/sml_frx_back.sv @@
// ----------------------------------------------------------------------------
// SML frame receiver back end
// Runs start hunt, frame store, end detection and CRC check; registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module sml_frx_back #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sml_frx_pkg::q_head_t   head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sml_frx_pkg::out_item_t out_item
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int CW = (FW > 9) ? FW : 9;
  localparam int SL = sml_frx_pkg::START_LENGTH;
  localparam logic [FW-1:0] FILL_FULL  = FW'(BUFFER_DEPTH);
  localparam logic [FW-1:0] FILL_START = FW'(SL);
  localparam logic [FW-1:0] FILL_SHIFT = FW'(SL - 1);

  // Read data source
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_WIN  = 2'd1;
  localparam logic [1:0] RD_MEM  = 2'd2;

  logic [FW-1:0] fill_r, fill_nxt, fill_inc;
  logic          in_frame_r, in_frame_nxt;
  logic          held_r, held_nxt;
  logic [15:0]   crc_r, crc_nxt, crc_upd;
  logic [7:0]    lag0_r, lag0_nxt, lag1_r, lag1_nxt;
  logic [7:0]    win_r  [SL];
  logic [7:0]    win_nxt[SL];
  logic [7:0]    win_wr [SL];
  logic [7:0]    hist_r  [SL];
  logic [7:0]    hist_nxt[SL];
  logic [7:0]    hist_sh [SL];
  logic [63:0]   win_flat;
  logic [39:0]   end_flat;
  logic          start_hit, end_hit, long_enough, crc_ok;
  logic          exec, wr_en;
  logic [2:0]    status_nxt;
  logic [1:0]    rd_sel_nxt;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rx_b;

  logic          out_valid_r;
  logic [2:0]    status_r;
  logic [10:0]   len_r;
  logic [1:0]    rd_sel_r;
  logic [7:0]    rd_win_r;
  logic [7:0]    rd_mem_r;
  logic [7:0]    mem [BUFFER_DEPTH];

  assign exec    = head.valid && (!out_valid_r || !out_stall);
  assign pop     = exec;
  assign rx_b    = head.item.rx_byte;
  assign rd_addr = AW'(head.item.read_index);

  always_comb begin
    fill_inc = fill_r + 1'b1;
    crc_upd  = sml_frx_pkg::crc_byte(crc_r, lag0_r);

    win_wr = win_r;
    win_wr[fill_r[2:0]] = rx_b;
    for (int i = 0; i < SL - 1; i++) begin
      hist_sh[i] = hist_r[i + 1];
    end
    hist_sh[SL-1] = rx_b;

    for (int i = 0; i < SL; i++) begin
      win_flat[63 - 8*i -: 8] = win_wr[i];
    end
    for (int i = 0; i < 5; i++) begin
      end_flat[39 - 8*i -: 8] = hist_sh[i];
    end
    start_hit   = (win_flat == sml_frx_pkg::START_SEQ);
    end_hit     = (end_flat == sml_frx_pkg::END_SEQ);
    long_enough = CW'(fill_inc) >= (CW'(hist_sh[5]) + CW'(SL));
    crc_ok      = (hist_sh[6] == ~crc_upd[7:0]) && (hist_sh[7] == ~crc_upd[15:8]);
  end

  always_comb begin
    fill_nxt     = fill_r;
    in_frame_nxt = in_frame_r;
    held_nxt     = held_r;
    crc_nxt      = crc_r;
    lag0_nxt     = lag0_r;
    lag1_nxt     = lag1_r;
    win_nxt      = win_r;
    hist_nxt     = hist_r;
    wr_en        = 1'b0;
    status_nxt   = sml_frx_pkg::ST_DONE;

    case (head.item.kind)
      sml_frx_pkg::CMD_BYTE: begin
        if (held_r) begin
          status_nxt = sml_frx_pkg::ST_DROPPED;
        end else if (!in_frame_r) begin
          status_nxt = sml_frx_pkg::ST_HUNT;
          win_nxt    = win_wr;
          fill_nxt   = fill_inc;
          if (fill_inc == FILL_START) begin
            if (start_hit) begin
              in_frame_nxt = 1'b1;
              crc_nxt      = sml_frx_pkg::CRC_START;
              lag0_nxt     = win_wr[SL-2];
              lag1_nxt     = win_wr[SL-1];
              hist_nxt     = win_wr;
              status_nxt   = sml_frx_pkg::ST_START;
            end else begin
              // slide the window by one; the newest byte stays in the last slot
              for (int i = 0; i < SL - 1; i++) begin
                win_nxt[i] = win_wr[i + 1];
              end
              fill_nxt = FILL_SHIFT;
            end
          end
        end else begin
          status_nxt = sml_frx_pkg::ST_RECV;
          wr_en      = 1'b1;
          fill_nxt   = fill_inc;
          crc_nxt    = crc_upd;
          lag0_nxt   = lag1_r;
          lag1_nxt   = rx_b;
          hist_nxt   = hist_sh;
          if (end_hit && long_enough) begin
            in_frame_nxt = 1'b0;
            if (crc_ok) begin
              held_nxt   = 1'b1;
              status_nxt = sml_frx_pkg::ST_GOOD;
            end else begin
              fill_nxt   = '0;
              status_nxt = sml_frx_pkg::ST_BAD;
            end
          end
          // a full buffer wins even over a good frame
          if (fill_nxt == FILL_FULL) begin
            fill_nxt     = '0;
            in_frame_nxt = 1'b0;
            held_nxt     = 1'b0;
            status_nxt   = sml_frx_pkg::ST_OVERFLOW;
          end
        end
      end
      sml_frx_pkg::CMD_RELEASE: begin
        if (held_r) begin
          fill_nxt     = '0;
          held_nxt     = 1'b0;
          in_frame_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (head.item.kind == sml_frx_pkg::CMD_READ && head.item.rd_in_range) begin
      rd_sel_nxt = head.item.rd_in_win ? RD_WIN : RD_MEM;
    end else begin
      rd_sel_nxt = RD_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      in_frame_r  <= 1'b0;
      held_r      <= 1'b0;
      crc_r       <= sml_frx_pkg::CRC_INIT;
      lag0_r      <= 8'h00;
      lag1_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        fill_r     <= fill_nxt;
        in_frame_r <= in_frame_nxt;
        held_r     <= held_nxt;
        crc_r      <= crc_nxt;
        lag0_r     <= lag0_nxt;
        lag1_r     <= lag1_nxt;
      end
      out_valid_r <= exec || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      win_r    <= win_nxt;
      hist_r   <= hist_nxt;
      status_r <= status_nxt;
      len_r    <= 11'(fill_nxt);
      rd_sel_r <= rd_sel_nxt;
      rd_win_r <= win_r[head.item.read_index[2:0]];
    end
  end

  // Frame store beyond the start window
  always_ff @(posedge clk) begin
    if (exec && wr_en) begin
      mem[fill_r[AW-1:0]] <= rx_b;
    end
    if (exec) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  always_comb begin
    out_item.status       = status_r;
    out_item.frame_length = len_r;
    case (rd_sel_r)
      RD_WIN:  out_item.read_data = rd_win_r;
      RD_MEM:  out_item.read_data = rd_mem_r;
      default: out_item.read_data = 8'h00;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ design/sml_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// SML frame receiver
// Hunts the SML start escape, stores the frame, checks its X-25 CRC and holds it.
// ----------------------------------------------------------------------------
//  Channel | Ports                          | Payload
//  --------+--------------------------------+---------------------------------
//  in      | in_valid, in_stall, in_item    | command, rx_byte, read_index
//  out     | out_valid, out_stall, out_item | status, frame_length, read_data
//
//  One item per clock while neither channel stalls; an accepted item passes
//  through the queue and then the execute register before its result is taken.
//  The CRC step and the single store write per byte sit in the execute cycle.
//  Reset is synchronous and clears control state; the frame store is not
//  cleared and needs no clearing pass.
//  out_stall holds the result and the back end; in_stall rises when two items wait.
// ----------------------------------------------------------------------------
`default_nettype none

module sml_frame_receiver #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sml_frx_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sml_frx_pkg::out_item_t out_item
);

  sml_frx_pkg::q_head_t head;
  logic                 pop;

  sml_frx_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  sml_frx_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ design/sml_frx_checker.sv @@
// ----------------------------------------------------------------------------
// SML frame receiver port checker
// Watches the top-level ports for result consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sml_frame_receiver_macros.svh"

module sml_frx_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input sml_frx_pkg::out_item_t out_item
);

  logic start_seen;
  logic discard_seen;
  logic data_seen;

  assign start_seen   = out_valid && (out_item.status == sml_frx_pkg::ST_START);
  assign discard_seen = out_valid && (out_item.status == sml_frx_pkg::ST_BAD ||
                                      out_item.status == sml_frx_pkg::ST_OVERFLOW);
  assign data_seen    = out_valid && (out_item.read_data != 8'h00);

  `SFR_ASSERT_RST(a_reset_idle, !rst_n, !out_valid && !in_stall)
  `SFR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `SFR_ASSERT_IMP(a_start_len, start_seen, out_item.frame_length == 11'd8)
  `SFR_ASSERT_IMP(a_discard_len, discard_seen, out_item.frame_length == 11'd0)
  `SFR_ASSERT_IMP(a_read_only_done, data_seen, out_item.status == sml_frx_pkg::ST_DONE)

endmodule

bind sml_frame_receiver sml_frx_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

@@ test/sml_frx_checker.sv @@
// ----------------------------------------------------------------------------
// SML frame receiver checker
// Watches both item channels, works out each expected result from its own copy
// of the receiver state (hunt window, frame store, lagged X-25 CRC, hold flag)
// and compares every result field by field with the oldest expectation.
// ----------------------------------------------------------------------------
package sml_frx_tb_pkg;

  localparam int          STORE_DEPTH = 1024;
  localparam logic [63:0] FRAME_START = 64'h1B1B_1B1B_0101_0101;
  localparam logic [39:0] FRAME_END   = 40'h1B_1B1B_1B1A;
  localparam logic [15:0] X25_POLY    = 16'h8408;

  // Reflected CRC-16/X-25, one byte, LSB first
  function automatic logic [15:0] x25_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ X25_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module sml_frx_tb_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  sml_frx_pkg::in_item_t  in_item,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  sml_frx_pkg::out_item_t out_item,
  output int                     mismatches,
  output int                     pending,
  output int                     store_extent
);
  import sml_frx_pkg::*;
  import sml_frx_tb_pkg::*;

  logic [7:0]  frame_mem [STORE_DEPTH];
  int          fill_level;
  bit          framing;
  bit          holding;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lag [2];
  out_item_t   expected_q [$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    store_extent = 0;
  end

  function automatic logic [2:0] take_rx_byte(input logic [7:0] b);
    logic [2:0]  st;
    logic [63:0] window;
    logic [39:0] tail;
    logic [15:0] fcs;
    int          pad;
    if (holding) begin
      return ST_DROPPED;
    end
    frame_mem[fill_level] = b;
    fill_level++;
    if (fill_level > store_extent) begin
      store_extent = fill_level;
    end
    if (!framing) begin
      st = ST_HUNT;
      if (fill_level >= START_LENGTH) begin
        window = '0;
        for (int k = 0; k < START_LENGTH; k++) begin
          window = {window[55:0], frame_mem[fill_level - START_LENGTH + k]};
        end
        if (window == FRAME_START) begin
          framing = 1'b1;
          crc_acc = 16'hFFFF;
          for (int k = 0; k < START_LENGTH - 2; k++) begin
            crc_acc = x25_next(crc_acc, frame_mem[k]);
          end
          crc_lag[0] = frame_mem[START_LENGTH - 2];
          crc_lag[1] = frame_mem[START_LENGTH - 1];
          st = ST_START;
        end else begin
          // slide the hunt window by one
          for (int k = 0; k < START_LENGTH - 1; k++) begin
            frame_mem[k] = frame_mem[k + 1];
          end
          fill_level--;
        end
      end
    end else begin
      st = ST_RECV;
      // the two newest bytes stay out of the CRC until they turn out not to be the FCS
      crc_acc    = x25_next(crc_acc, crc_lag[0]);
      crc_lag[0] = crc_lag[1];
      crc_lag[1] = b;
      if (fill_level >= 8) begin
        tail = '0;
        for (int k = 0; k < 5; k++) begin
          tail = {tail[31:0], frame_mem[fill_level - 8 + k]};
        end
        pad = frame_mem[fill_level - 3];
        if (tail == FRAME_END && fill_level >= 8 + pad) begin
          fcs = ~crc_acc;
          if (frame_mem[fill_level - 2] == fcs[7:0] &&
              frame_mem[fill_level - 1] == fcs[15:8]) begin
            holding = 1'b1;
            st = ST_GOOD;
          end else begin
            fill_level = 0;
            st = ST_BAD;
          end
          framing = 1'b0;
        end
      end
    end
    // a full store wins even over a good frame completing on this byte
    if (fill_level >= STORE_DEPTH) begin
      fill_level = 0;
      framing    = 1'b0;
      holding    = 1'b0;
      st         = ST_OVERFLOW;
    end
    return st;
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    r = '0;
    r.status = ST_DONE;
    case (it.command)
      CMD_BYTE: begin
        r.status = take_rx_byte(it.rx_byte);
      end
      CMD_RELEASE: begin
        if (holding) begin
          fill_level = 0;
          holding    = 1'b0;
          framing    = 1'b0;
        end
      end
      CMD_READ: begin
        r.read_data = frame_mem[it.read_index];
      end
      default: ;
    endcase
    r.frame_length = 11'(fill_level);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      fill_level = 0;
      framing    = 1'b0;
      holding    = 1'b0;
      crc_acc    = 16'hFFFF;
      crc_lag[0] = 8'h00;
      crc_lag[1] = 8'h00;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_result(in_item));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $error("unexpected result: status %0d, frame_length %0d, read_data %02h",
                 out_item.status, out_item.frame_length, out_item.read_data);
        end else begin
          want = expected_q.pop_front();
          if (out_item.status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
          end
          if (out_item.frame_length !== want.frame_length) begin
            mismatches++;
            $error("frame_length: expected %0d, actual %0d",
                   want.frame_length, out_item.frame_length);
          end
          if (out_item.read_data !== want.read_data) begin
            mismatches++;
            $error("read_data: expected %02h, actual %02h", want.read_data, out_item.read_data);
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// SML frame receiver testbench
// Drives command items into the receiver: a short directed opening, one frame
// that fills the store exactly, then random frames (good, bad FCS, short end
// escape, unterminated) mixed with reads, releases and noise, under random
// idling on both channels. The checker beside the block judges each result.
// ----------------------------------------------------------------------------
module testbench;
  import sml_frx_pkg::*;
  import sml_frx_tb_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_PCT    = 21;
  localparam int RANDOM_ITEMS = 650;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int mismatches;
  int pending;
  int store_extent;
  int items_sent    = 0;
  int hold_requests = 0;
  bit gaps_on       = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sml_frame_receiver #(
    .BUFFER_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  sml_frx_tb_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .mismatches   (mismatches),
    .pending      (pending),
    .store_extent (store_extent)
  );

  // Result side: random stalls, or a long hold when one is requested
  initial begin : receiver
    int served;
    served = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    repeat (RUN_LIMIT) @(posedge clk);
    $display("sml_frame_receiver regression: fail");
    $finish;
  end

  function automatic in_item_t item_of(input logic [1:0] cmd, input logic [7:0] b,
                                       input logic [9:0] idx);
    in_item_t it;
    it.command    = cmd;
    it.rx_byte    = b;
    it.read_index = idx;
    return it;
  endfunction

  // Called and returns at a falling edge; valid stays up for a following item
  task automatic offer(input in_item_t it);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (it.command != CMD_NOP) items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer(item_of(CMD_BYTE, b, 10'($urandom_range(0, 1023))));
  endtask

  task automatic send_ctrl(input logic [1:0] cmd);
    offer(item_of(cmd, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023))));
  endtask

  // Only entries already written are read
  task automatic send_read();
    if (store_extent == 0) return;
    offer(item_of(CMD_READ, 8'($urandom_range(0, 255)),
                  10'($urandom_range(0, store_extent - 1))));
  endtask

  task automatic send_frame(input int body_len, input int pad, input bit bad_fcs,
                            input bit short_end);
    logic [7:0]  octets [$];
    logic [15:0] fcs;
    octets = {};
    for (int k = 0; k < 8; k++) octets.push_back(FRAME_START[63 - 8*k -: 8]);
    // an end escape whose padding asks for more than is stored must be passed over
    if (short_end) begin
      for (int k = 0; k < 5; k++) octets.push_back(FRAME_END[39 - 8*k -: 8]);
      octets.push_back(8'($urandom_range(9, 255)));
      octets.push_back(8'($urandom_range(0, 255)));
      octets.push_back(8'($urandom_range(0, 255)));
    end
    for (int k = 0; k < body_len; k++) octets.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < 5; k++) octets.push_back(FRAME_END[39 - 8*k -: 8]);
    octets.push_back(8'(pad));
    fcs = 16'hFFFF;
    foreach (octets[k]) fcs = x25_next(fcs, octets[k]);
    fcs = ~fcs;
    if (bad_fcs) fcs[7:0] = fcs[7:0] ^ 8'($urandom_range(1, 255));
    octets.push_back(fcs[7:0]);
    octets.push_back(fcs[15:8]);
    foreach (octets[k]) begin
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 1)) send_read();
        else send_ctrl(CMD_NOP);
      end
      send_byte(octets[k]);
    end
  endtask

  // Poke a held frame, then usually let it go
  task automatic settle_held();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
      else send_read();
    end
    if ($urandom_range(0, 9) != 0) send_ctrl(CMD_RELEASE);
  endtask

  initial begin : stimulus
    int base;
    int body;
    int pad;
    int pick;
    bit held_off;
    bit drained;
    held_off = 1'b0;
    drained  = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening
    offer(item_of(CMD_NOP, 8'hFF, 10'h3FF));
    offer(item_of(CMD_NOP, 8'h00, 10'h000));
    send_ctrl(CMD_RELEASE);
    send_byte(8'h00);
    send_byte(8'hFF);
    offer(item_of(CMD_READ, 8'hA5, 10'd0));
    offer(item_of(CMD_READ, 8'h5A, 10'd1));
    send_frame(0, 0, 1'b0, 1'b0);
    send_byte(8'h1B);
    send_read();
    send_ctrl(CMD_RELEASE);

    // fill the store exactly with a good frame, then a bad FCS
    send_frame(STORE_DEPTH - 24, 0, 1'b0, 1'b1);
    send_frame(2, 1, 1'b1, 1'b0);

    base = items_sent;
    while (items_sent < base + RANDOM_ITEMS) begin
      gaps_on = !(items_sent >= base + 250 && items_sent < base + 400);
      if (!held_off && items_sent >= base + 150) begin
        hold_requests++;
        held_off = 1'b1;
      end
      if (!drained && items_sent >= base + 450) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
      pad  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8 + body) : $urandom_range(0, 3);
      if (pick < 55) begin
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        send_frame(body, pad, 1'b0, 1'b0);
        settle_held();
      end else if (pick < 65) begin
        send_frame(body, pad, 1'b1, 1'b0);
      end else if (pick < 72) begin
        send_frame(body, pad, 1'b0, 1'b1);
        settle_held();
      end else if (pick < 77) begin
        // start without an end: the next frame closes it
        for (int k = 0; k < 8; k++) send_byte(FRAME_START[63 - 8*k -: 8]);
        repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0:       send_byte(8'($urandom_range(0, 255)));
            1:       send_read();
            2:       send_ctrl(CMD_RELEASE);
            default: send_ctrl(CMD_NOP);
          endcase
        end
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("sml_frame_receiver regression: pass");
    end else begin
      $display("sml_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule

@@ sml_frame_receiver.f @@
+incdir+design
design/sml_frx_pkg.sv
design/sml_frx_front.sv
design/sml_frx_back.sv
design/sml_frame_receiver.sv
design/sml_frx_checker.sv
test/sml_frx_checker.sv
test/testbench.sv
